// ===== rtl/key_remap_typematic_repeat_unit_assert.svh =====
// Assertion macros used by the top RTL file of the typematic repeat unit.
`ifndef KEY_REMAP_TYPEMATIC_REPEAT_UNIT_ASSERT_SVH
`define KEY_REMAP_TYPEMATIC_REPEAT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define KRTR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define KRTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KRTR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define KRTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/krtr_pkg.sv =====
`default_nettype none
package krtr_pkg;

	localparam int KEY_BITS_DEF = 64;
	localparam int OUT_W = 64;
	localparam int RAW_W = 32;
	localparam int ELAPSED_W = 4;
	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 5 * OUT_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 7;
	localparam int PAIR_COUNT = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_SELECT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_FIRST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_FIRST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD = 3'd4;

	localparam logic LAYOUT_GAME = 1'b0;

	localparam logic [6:0] REPEAT_FIRST_RST = 7'd24;
	localparam logic [6:0] REPEAT_PERIOD_RST = 7'd6;
	localparam logic [6:0] FAST_FIRST_RST = 7'd18;
	localparam logic [6:0] FAST_PERIOD_RST = 7'd3;

	localparam logic [RAW_W-1:0] KEY_MAP_ROW0 [64] = '{
		32'h00080008, 32'h00040004, 32'h00020002, 32'h00010001,
		32'h00000020, 32'h00000040, 32'h00000200, 32'h00000100,
		32'h00000000, 32'h00000400, 32'h00000100, 32'h00000040,
		32'h00001000, 32'h00001000, 32'h00800000, 32'h00400000,
		32'h00000800, 32'h00000400, 32'h00000200, 32'h00000100,
		32'h00000800, 32'h00000010, 32'h00000040, 32'h00000020,
		32'h00080008, 32'h00040004, 32'h00020002, 32'h00010001,
		32'h00000010, 32'h00001000, 32'h00000200, 32'h00000100,
		32'h00000001, 32'h00000002, 32'h00000004, 32'h00000008,
		32'h00200000, 32'h00100000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
	};

	localparam logic [5:0] PAIR_A [PAIR_COUNT] = '{
		6'd0, 6'd2, 6'd24, 6'd27, 6'd35, 6'd32, 6'd14, 6'd37
	};
	localparam logic [5:0] PAIR_B [PAIR_COUNT] = '{
		6'd1, 6'd3, 6'd25, 6'd26, 6'd34, 6'd33, 6'd15, 6'd36
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [7:0] slow;
		logic signed [7:0] fast;
	} timer_pair_t;

	typedef struct packed {
		logic we;
		timer_pair_t data;
	} ram_wr_t;

	typedef struct packed {
		logic pulse;
		logic signed [7:0] value;
	} tmr_res_t;

endpackage
`default_nettype wire

// ===== rtl/krtr_key_map.sv =====
`default_nettype none
module krtr_key_map import krtr_pkg::*; #(
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  wire logic [RAW_W-1:0]    raw_buttons,
	input  wire logic                pad_error,
	input  wire logic                layout_select,
	output logic      [KEY_BITS-1:0] keys_held
);

	logic [KEY_BITS-1:0] mapped;

	always_comb begin
		mapped = '0;
		for (int i = 0; i < KEY_BITS; i++) begin
			mapped[i] = (layout_select == LAYOUT_GAME) && !pad_error &&
				(|(raw_buttons & KEY_MAP_ROW0[i]));
		end
	end

	// Opposite directions pressed together cancel each other.
	always_comb begin
		keys_held = mapped;
		for (int p = 0; p < PAIR_COUNT; p++) begin
			if (mapped[int'(PAIR_A[p])] && mapped[int'(PAIR_B[p])]) begin
				keys_held[int'(PAIR_A[p])] = 1'b0;
				keys_held[int'(PAIR_B[p])] = 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/krtr_timer_ram.sv =====
`default_nettype none
module krtr_timer_ram import krtr_pkg::*; #(
	parameter int DEPTH = KEY_BITS_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output timer_pair_t        rd_data,
	input  wire ram_wr_t       wr,
	input  wire logic [AW-1:0] wr_addr
);

	timer_pair_t mem [DEPTH];
	timer_pair_t rd_q;
	logic [DEPTH-1:0] valid_q;
	logic hit_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr_addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// An entry never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (wr.we) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = hit_q ? rd_q : '0;

endmodule
`default_nettype wire

// ===== rtl/key_remap_typematic_repeat_unit.sv =====
// A result beat is loaded into the output register after the key sweep ends, once that register is free.
// An input beat is taken only in idle, so each item waits for the key sweep that reads and writes
// back one timer memory entry per cycle.
// The next input beat is taken while an earlier result still waits on the output register.
// Reset clears the held keys, loads the register defaults and marks every timer entry
// unwritten, so it reads as zero; there is no clearing pass.
`default_nettype none
`include "key_remap_typematic_repeat_unit_assert.svh"
module key_remap_typematic_repeat_unit import krtr_pkg::*; #(
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// raw_buttons[31:0], elapsed_frames[35:32], zero fill[39:36]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// pad_error
	input  wire logic                  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// keys_held[63:0], keys_pressed[127:64], keys_released[191:128],
	// keys_repeat[255:192], keys_repeat_fast[319:256]
	output logic      [OUT_DATA_W-1:0] m_tdata
);

	localparam int AW = $clog2(KEY_BITS);
	localparam int CW = $clog2(KEY_BITS + 1);
	localparam logic [CW-1:0] END_CNT = CW'(KEY_BITS);
	localparam logic [AW-1:0] LAST_IDX = AW'(KEY_BITS - 1);

	state_t state_q, state_d;
	logic layout_q;
	logic [6:0] rep_first_q, rep_period_q, fast_first_q, fast_period_q;
	logic [KEY_BITS-1:0] held_new, held_q, pressed_q, released_q, rep_q, repf_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [CW-1:0] rd_cnt_q;
	logic v_s1;
	logic [AW-1:0] idx_s1;
	logic issue, accept, out_load;
	logic m_tvalid_q;
	logic [OUT_DATA_W-1:0] out_q;
	timer_pair_t rd_data;
	ram_wr_t ram_wr;
	tmr_res_t slow_res, fast_res;

	function automatic tmr_res_t tmr_step(
		input logic signed [7:0] t,
		input logic h,
		input logic p,
		input logic [6:0] first,
		input logic [6:0] period,
		input logic [ELAPSED_W-1:0] e
	);
		tmr_res_t r;
		logic signed [7:0] cur;
		logic signed [8:0] diff;
		cur = t;
		r.pulse = 1'b0;
		r.value = $signed({1'b0, first});
		diff = '0;
		if (h) begin
			if (p) begin
				r.pulse = 1'b1;
			end else if (cur <= 8'sd0) begin
				r.pulse = 1'b1;
				cur = $signed({1'b0, period});
			end
			diff = $signed({cur[7], cur}) - $signed({5'b0, e});
			if (diff < -9'sd128) begin
				r.value = -8'sd128;
			end else begin
				r.value = diff[7:0];
			end
		end
		return r;
	endfunction

	krtr_key_map #(
		.KEY_BITS(KEY_BITS)
	) u_key_map (
		.raw_buttons(s_tdata[RAW_W-1:0]),
		.pad_error(s_tuser),
		.layout_select(layout_q),
		.keys_held(held_new)
	);

	krtr_timer_ram #(
		.DEPTH(KEY_BITS),
		.AW(AW)
	) u_timer_ram (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(issue),
		.rd_addr(rd_cnt_q[AW-1:0]),
		.rd_data(rd_data),
		.wr(ram_wr),
		.wr_addr(idx_s1)
	);

	always_comb begin
		slow_res = tmr_step(rd_data.slow, held_q[idx_s1], pressed_q[idx_s1],
			rep_first_q, rep_period_q, elapsed_q);
		fast_res = tmr_step(rd_data.fast, held_q[idx_s1], pressed_q[idx_s1],
			fast_first_q, fast_period_q, elapsed_q);
		ram_wr.we = v_s1;
		ram_wr.data.slow = slow_res.value;
		ram_wr.data.fast = fast_res.value;
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		issue = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				issue = (rd_cnt_q != END_CNT);
				if (v_s1 && idx_s1 == LAST_IDX) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				out_load = !m_tvalid_q || m_tready;
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			layout_q <= LAYOUT_GAME;
			rep_first_q <= REPEAT_FIRST_RST;
			rep_period_q <= REPEAT_PERIOD_RST;
			fast_first_q <= FAST_FIRST_RST;
			fast_period_q <= FAST_PERIOD_RST;
			held_q <= '0;
			rd_cnt_q <= '0;
			v_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_LAYOUT_SELECT: layout_q <= cfg_data[0];
					CFG_REPEAT_FIRST: rep_first_q <= cfg_data;
					CFG_REPEAT_PERIOD: rep_period_q <= cfg_data;
					CFG_FAST_FIRST: fast_first_q <= cfg_data;
					CFG_FAST_PERIOD: fast_period_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				held_q <= held_new;
				rd_cnt_q <= '0;
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			v_s1 <= issue;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pressed_q <= held_new & ~held_q;
			released_q <= held_q & ~held_new;
			elapsed_q <= s_tdata[RAW_W +: ELAPSED_W];
			rep_q <= '0;
			repf_q <= '0;
		end
		if (issue) begin
			idx_s1 <= rd_cnt_q[AW-1:0];
		end
		if (v_s1) begin
			rep_q[idx_s1] <= slow_res.pulse;
			repf_q[idx_s1] <= fast_res.pulse;
		end
		if (out_load) begin
			out_q <= {OUT_W'(repf_q), OUT_W'(rep_q), OUT_W'(released_q),
				OUT_W'(pressed_q), OUT_W'(held_q)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = out_q;

	`KRTR_ASSERT_NEXT(a_accept_starts_sweep, clk, arst_n, accept,
		state_q == ST_SWEEP, "accept did not start a sweep")
	`KRTR_ASSERT_IMPLY(a_write_in_sweep, clk, arst_n, ram_wr.we,
		state_q == ST_SWEEP, "timer write outside sweep")
	`KRTR_ASSERT_IMPLY(a_press_repeats, clk, arst_n, out_load,
		((pressed_q & ~rep_q) == '0) && ((pressed_q & ~repf_q) == '0),
		"press edge missing from repeat words")
	`KRTR_ASSERT_IMPLY(a_edges_disjoint, clk, arst_n, state_q == ST_DONE,
		(pressed_q & released_q) == '0, "key both pressed and released")

endmodule
`default_nettype wire
